/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the Hough line accumulator RTL.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge once reset has been released.
`define HLA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define HLA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HLA_ASSERT(lbl, prop, msg)
`define HLA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* hw/rtl/hla_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hla_pkg
// Types, codes and the sine/cosine helper of the Hough line accumulator.
// ----------------------------------------------------------------------------
package hla_pkg;

    // Width of the pixel position carried to the vote unit (covers 4096 columns).
    localparam int POS_W = 12;

    localparam real TWO_PI = 6.283185307179586;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH = 2'd0,
        CFG_RHO_RECIP   = 2'd1,
        CFG_THRESHOLD   = 2'd2
    } cfg_index_t;

    // Input action codes.
    typedef enum logic [1:0] {
        ACT_PIXEL = 2'd0,
        ACT_FETCH = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    // Work handed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_VOTE  = 2'd0,
        OP_FETCH = 2'd1,
        OP_CLEAR = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
    } op_t;

    // Status returned by the back end to the front end.
    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        ST_CLEAR     = 3'd0,
        ST_IDLE      = 3'd1,
        ST_VOTE      = 3'd2,
        ST_SCAN_PREP = 3'd3,
        ST_SCAN_RD   = 3'd4,
        ST_SCAN_CHK  = 3'd5
    } back_state_t;

    // Rounds a value in [-1, 1] to Q1.14, half away from zero.
    function automatic logic signed [15:0] to_q14(input real v);
        real s;
        begin
            s = v * 16384.0;
            if (s >= 0.0)
            begin
                to_q14 = 16'($rtoi($floor(s + 0.5)));
            end
            else
            begin
                to_q14 = 16'(-$rtoi($floor(-s + 0.5)));
            end
        end
    endfunction

endpackage

/* hw/rtl/hla_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hla_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/hla_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hla_queue
// Two-entry queue of work items between the front end and the back end.
// ----------------------------------------------------------------------------
module hla_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hla_pkg::op_t  push_data,
    output logic          full,
    input  logic          pop,
    output hla_pkg::op_t  pop_data,
    output logic          empty
);

    hla_pkg::op_t entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* hw/rtl/hla_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hla_front
// Front end: accepts input beats, tracks the raster position and queues work.
// ----------------------------------------------------------------------------
module hla_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [7:0]            pixel,
    input  logic [10:0]           image_width,
    input  hla_pkg::back_status_t status,
    input  logic                  q_full,
    output logic                  q_push,
    output hla_pkg::op_t          q_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int WCL = $clog2(MAX_WIDTH + 1);
    localparam int WC  = (WCL > 11) ? WCL : 11;

    logic [XW-1:0] col_reg;
    logic [XW-1:0] col_next;
    logic [XW-1:0] row_reg;
    logic [XW-1:0] row_next;
    logic [WC-1:0] w_eff;
    logic [WC-1:0] col_inc;
    logic          accept;

    assign in_ready = !q_full && !status.clearing;
    assign accept   = in_valid && in_ready;

    // Effective row width: zero acts as one, oversize clips to the maximum.
    always_comb
    begin
        if (image_width == 11'd0)
        begin
            w_eff = WC'(1);
        end
        else if (WC'(image_width) > WC'(MAX_WIDTH))
        begin
            w_eff = WC'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WC'(image_width);
        end
    end

    assign col_inc = WC'(col_reg) + WC'(1);

    // Classify the beat and work out the next raster position.
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        q_push      = 1'b0;
        q_data.kind = hla_pkg::OP_VOTE;
        q_data.x    = hla_pkg::POS_W'(col_reg);
        q_data.y    = hla_pkg::POS_W'(row_reg);
        if (accept)
        begin
            case (hla_pkg::action_t'(action))
                hla_pkg::ACT_PIXEL:
                begin
                    q_push = (pixel == 8'd1);
                    if (col_inc >= w_eff)
                    begin
                        col_next = '0;
                        row_next = (row_reg == XW'(MAX_WIDTH - 1)) ? '0 : row_reg + XW'(1);
                    end
                    else
                    begin
                        col_next = col_reg + XW'(1);
                    end
                end
                hla_pkg::ACT_FETCH:
                begin
                    q_push      = 1'b1;
                    q_data.kind = hla_pkg::OP_FETCH;
                end
                hla_pkg::ACT_CLEAR:
                begin
                    q_push      = 1'b1;
                    q_data.kind = hla_pkg::OP_CLEAR;
                    col_next    = '0;
                    row_next    = '0;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    // Raster position counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* hw/rtl/hla_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hla_back
// Back end: vote pipeline, threshold scan and clearing sweep over the store.
// ----------------------------------------------------------------------------
module hla_back #(
    parameter int THETA_BINS = 360,
    parameter int RHO_BINS   = 2048,
    parameter int COUNT_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  op_empty,
    input  hla_pkg::op_t          op_data,
    output logic                  op_pop,
    input  logic [12:0]           rho_recip,
    input  logic [15:0]           threshold,
    output hla_pkg::back_status_t status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  found,
    output logic [10:0]           rho_bin,
    output logic [8:0]            theta_bin,
    output logic [15:0]           votes
);

    localparam int CELLS = RHO_BINS * THETA_BINS;
    localparam int AW    = $clog2(CELLS);
    localparam int PW    = $clog2(CELLS + 1);
    localparam int TW    = $clog2(THETA_BINS);
    localparam int RBW   = $clog2(RHO_BINS);
    localparam int XW    = hla_pkg::POS_W;
    localparam int PRW   = XW + 17;
    localparam int SUMW  = PRW + 1;
    localparam int MW    = SUMW - 1 + 13;
    localparam int BINW  = MW + 1 - 26;
    localparam int BW    = (BINW > RBW) ? BINW : RBW;
    localparam int LW    = COUNT_BITS + 16;

    hla_pkg::back_state_t state_reg;
    hla_pkg::back_state_t state_next;

    // Sine and cosine of each theta bin, Q1.14.
    logic signed [15:0] sin_tab [THETA_BINS];
    logic signed [15:0] cos_tab [THETA_BINS];

    for (genvar g = 0; g < THETA_BINS; g++)
    begin : g_rom
        localparam real ANGLE = hla_pkg::TWO_PI * g / THETA_BINS;
        assign sin_tab[g] = hla_pkg::to_q14($sin(ANGLE));
        assign cos_tab[g] = hla_pkg::to_q14($cos(ANGLE));
    end

    // Vote pipeline registers.
    logic [TW-1:0]         k_reg;
    logic [XW-1:0]         vx_reg;
    logic [XW-1:0]         vy_reg;
    logic                  v1_reg;
    logic [TW-1:0]         k1_reg;
    logic [XW-1:0]         x1_reg;
    logic [XW-1:0]         y1_reg;
    logic signed [15:0]    sin1_reg;
    logic signed [15:0]    cos1_reg;
    logic                  v2_reg;
    logic [TW-1:0]         k2_reg;
    logic signed [PRW-1:0] px2_reg;
    logic signed [PRW-1:0] py2_reg;
    logic                  v3_reg;
    logic [TW-1:0]         k3_reg;
    logic [SUMW-2:0]       rho3_reg;
    logic                  v4_reg;
    logic [TW-1:0]         k4_reg;
    logic [MW-1:0]         prod4_reg;
    logic                  v5_reg;
    logic [AW-1:0]         addr5_reg;
    logic                  v6_reg;
    logic [AW-1:0]         addr6_reg;

    logic signed [SUMW-1:0] rho_sum;
    logic [MW:0]            rounded;
    logic [BW-1:0]          bin;
    logic                   pipe_idle;

    // Scan, clear and peak registers.
    logic [PW-1:0]         ptr_reg;
    logic [RBW-1:0]        scan_rho_reg;
    logic [TW-1:0]         scan_theta_reg;
    logic [LW-1:0]         limit_reg;
    logic [AW-1:0]         clr_addr_reg;
    logic [COUNT_BITS-1:0] peak_reg;

    // Result register.
    logic                  out_valid_reg;
    logic                  found_reg;
    logic [10:0]           rho_bin_reg;
    logic [8:0]            theta_bin_reg;
    logic [15:0]           votes_reg;

    // Store ports.
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [AW-1:0]         ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] count_inc;

    logic                  hit;
    logic                  last_cell;
    logic                  out_load;
    logic                  out_found;

    hla_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pipe_idle = !(v1_reg || v2_reg || v3_reg || v4_reg || v5_reg || v6_reg);
    assign rho_sum   = SUMW'(px2_reg) + SUMW'(py2_reg);
    assign rounded   = (MW + 1)'(prod4_reg) + ((MW + 1)'(1) << 25);
    assign bin       = BW'(rounded >> 26);
    assign count_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
    assign hit       = ({ram_rdata, 16'd0} > limit_reg);
    assign last_cell = (ptr_reg == PW'(CELLS - 1));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hla_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == AW'(CELLS - 1))
                begin
                    state_next = hla_pkg::ST_IDLE;
                end
            end
            hla_pkg::ST_IDLE:
            begin
                if (op_pop)
                begin
                    case (op_data.kind)
                        hla_pkg::OP_VOTE:  state_next = hla_pkg::ST_VOTE;
                        hla_pkg::OP_FETCH: state_next = hla_pkg::ST_SCAN_PREP;
                        hla_pkg::OP_CLEAR: state_next = hla_pkg::ST_CLEAR;
                        default:           state_next = hla_pkg::ST_IDLE;
                    endcase
                end
            end
            hla_pkg::ST_VOTE:
            begin
                if (k_reg == TW'(THETA_BINS - 1))
                begin
                    state_next = hla_pkg::ST_IDLE;
                end
            end
            hla_pkg::ST_SCAN_PREP:
            begin
                state_next = (ptr_reg == PW'(CELLS)) ? hla_pkg::ST_IDLE : hla_pkg::ST_SCAN_RD;
            end
            hla_pkg::ST_SCAN_RD:
            begin
                state_next = hla_pkg::ST_SCAN_CHK;
            end
            hla_pkg::ST_SCAN_CHK:
            begin
                state_next = (hit || last_cell) ? hla_pkg::ST_IDLE : hla_pkg::ST_SCAN_RD;
            end
            default:
            begin
                state_next = hla_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: queue pop, store ports and result loads.
    always_comb
    begin
        op_pop    = 1'b0;
        ram_we    = v6_reg;
        ram_waddr = addr6_reg;
        ram_wdata = count_inc;
        ram_raddr = addr5_reg;
        out_load  = 1'b0;
        out_found = 1'b0;
        case (state_reg)
            hla_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            hla_pkg::ST_IDLE:
            begin
                if (!op_empty)
                begin
                    case (op_data.kind)
                        hla_pkg::OP_VOTE:  op_pop = 1'b1;
                        hla_pkg::OP_FETCH: op_pop = pipe_idle && !out_valid_reg;
                        hla_pkg::OP_CLEAR: op_pop = pipe_idle;
                        default:           op_pop = 1'b0;
                    endcase
                end
            end
            hla_pkg::ST_SCAN_PREP:
            begin
                out_load = (ptr_reg == PW'(CELLS));
            end
            hla_pkg::ST_SCAN_RD:
            begin
                ram_raddr = ptr_reg[AW-1:0];
            end
            hla_pkg::ST_SCAN_CHK:
            begin
                out_load  = hit || last_cell;
                out_found = hit;
            end
            default:
            begin
                op_pop = 1'b0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hla_pkg::ST_CLEAR;
            clr_addr_reg   <= '0;
            k_reg          <= '0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            v6_reg         <= 1'b0;
            ptr_reg        <= '0;
            scan_rho_reg   <= '0;
            scan_theta_reg <= '0;
            peak_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Clearing sweep, restarted by a clear operation.
            if (state_reg == hla_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            else
            begin
                clr_addr_reg <= '0;
            end

            // Theta counter of the pixel being voted.
            if (state_reg == hla_pkg::ST_VOTE)
            begin
                k_reg <= k_reg + TW'(1);
            end
            else
            begin
                k_reg <= '0;
            end

            // Valid bits of the vote pipeline.
            v1_reg <= (state_reg == hla_pkg::ST_VOTE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg && !rho_sum[SUMW-1];
            v4_reg <= v3_reg;
            v5_reg <= v4_reg && (bin < BW'(RHO_BINS));
            v6_reg <= v5_reg;

            // Peak count after each vote; cleared with the store.
            if (op_pop && (op_data.kind == hla_pkg::OP_CLEAR))
            begin
                peak_reg <= '0;
            end
            else if (v6_reg && (count_inc > peak_reg))
            begin
                peak_reg <= count_inc;
            end

            // Scan pointer with its rho and theta coordinates.
            if (op_pop && (op_data.kind == hla_pkg::OP_CLEAR))
            begin
                ptr_reg        <= '0;
                scan_rho_reg   <= '0;
                scan_theta_reg <= '0;
            end
            else if (state_reg == hla_pkg::ST_SCAN_CHK)
            begin
                ptr_reg <= ptr_reg + PW'(1);
                if (scan_theta_reg == TW'(THETA_BINS - 1))
                begin
                    scan_theta_reg <= '0;
                    scan_rho_reg   <= scan_rho_reg + RBW'(1);
                end
                else
                begin
                    scan_theta_reg <= scan_theta_reg + TW'(1);
                end
            end

            // Result register: loaded by the scan, freed by the consumer.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the pipeline, scan and result.
    always_ff @(posedge clk)
    begin
        if (op_pop)
        begin
            vx_reg <= op_data.x;
            vy_reg <= op_data.y;
        end
        k1_reg    <= k_reg;
        x1_reg    <= vx_reg;
        y1_reg    <= vy_reg;
        sin1_reg  <= sin_tab[k_reg];
        cos1_reg  <= cos_tab[k_reg];
        k2_reg    <= k1_reg;
        px2_reg   <= PRW'($signed({1'b0, x1_reg}) * cos1_reg);
        py2_reg   <= PRW'($signed({1'b0, y1_reg}) * sin1_reg);
        k3_reg    <= k2_reg;
        rho3_reg  <= rho_sum[SUMW-2:0];
        k4_reg    <= k3_reg;
        prod4_reg <= MW'(rho3_reg * rho_recip);
        addr5_reg <= AW'(bin[RBW-1:0] * THETA_BINS + k4_reg);
        addr6_reg <= addr5_reg;
        if (state_reg == hla_pkg::ST_SCAN_PREP)
        begin
            limit_reg <= LW'(threshold * peak_reg);
        end
        if (out_load)
        begin
            found_reg     <= out_found;
            rho_bin_reg   <= out_found ? 11'(scan_rho_reg) : 11'd0;
            theta_bin_reg <= out_found ? 9'(scan_theta_reg) : 9'd0;
            votes_reg     <= out_found ? 16'(ram_rdata) : 16'd0;
        end
    end

    assign status.clearing = (state_reg == hla_pkg::ST_CLEAR);
    assign out_valid       = out_valid_reg;
    assign found           = found_reg;
    assign rho_bin         = rho_bin_reg;
    assign theta_bin       = theta_bin_reg;
    assign votes           = votes_reg;

endmodule

/* hw/rtl/hough_line_accumulator.sv */
`timescale 1ns / 1ps
// A foreground pixel (byte value 1) makes at most one read-modify-write of
// the vote store per theta bin; other pixels only advance the raster position
// in the front end. A fetch examines the store cells one at a time, each in a
// read state and a check state, until it finds a cell above threshold or
// reaches the end. After reset and after each clear the store is swept to zero
// over all RHO_BINS * THETA_BINS cells (737280 at the default size), during
// which no input beat is taken; configuration writes are always taken.
// ----------------------------------------------------------------------------
// hough_line_accumulator
// Hough transform line accumulator with threshold search over the vote store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hough_line_accumulator #(
    parameter int THETA_BINS = 360,
    parameter int RHO_BINS   = 2048,
    parameter int MAX_WIDTH  = 1024,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [10:0] rho_bin,
    output logic [8:0]  theta_bin,
    output logic [15:0] votes
);

    logic [10:0]           image_width_reg;
    logic [12:0]           rho_recip_reg;
    logic [15:0]           threshold_reg;
    hla_pkg::back_status_t status;
    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    hla_pkg::op_t          q_in;
    hla_pkg::op_t          q_out;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= 11'd256;
            rho_recip_reg   <= 13'd4096;
            threshold_reg   <= 16'd32768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (hla_pkg::cfg_index_t'(cfg_index))
                hla_pkg::CFG_IMAGE_WIDTH: image_width_reg <= cfg_data[10:0];
                hla_pkg::CFG_RHO_RECIP:   rho_recip_reg   <= cfg_data[12:0];
                hla_pkg::CFG_THRESHOLD:   threshold_reg   <= cfg_data;
                default:                  threshold_reg   <= threshold_reg;
            endcase
        end
    end

    hla_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .pixel       (pixel),
        .image_width (image_width_reg),
        .status      (status),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    hla_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    hla_back #(
        .THETA_BINS (THETA_BINS),
        .RHO_BINS   (RHO_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_empty  (q_empty),
        .op_data   (q_out),
        .op_pop    (q_pop),
        .rho_recip (rho_recip_reg),
        .threshold (threshold_reg),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .rho_bin   (rho_bin),
        .theta_bin (theta_bin),
        .votes     (votes)
    );

    // The queue is never written while full.
    `HLA_ASSERT_ALWAYS(a_queue_no_overflow, q_push |-> !q_full, "work queue overflow")
    // The queue is never popped while empty.
    `HLA_ASSERT_ALWAYS(a_queue_no_underflow, q_pop |-> !q_empty, "work queue underflow")
    // An end-of-scan beat carries zero coordinates and count.
    `HLA_ASSERT(a_done_zero,
        (out_valid && !found) |-> (rho_bin == 11'd0 && theta_bin == 9'd0 && votes == 16'd0),
        "end-of-scan beat with non-zero fields")
    // A returned cell lies inside the theta range.
    `HLA_ASSERT(a_theta_range, (out_valid && found) |-> (theta_bin < THETA_BINS),
        "theta bin out of range")

endmodule
